// File: rtl/core/lvwd_pkg.sv
// Shared types and constants of the local variance wavelet denoiser.
`default_nettype none
package lvwd_pkg;

  localparam int COEF_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WREG_W     = 12;
  localparam int HREG_W     = 13;
  localparam int NOISE_W    = 32;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_VARIANCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_WINDOW   = 2'd3;

  localparam logic [WREG_W-1:0]  RST_IMAGE_WIDTH    = 12'd512;
  localparam logic [HREG_W-1:0]  RST_IMAGE_HEIGHT   = 13'd512;
  localparam logic [NOISE_W-1:0] RST_NOISE_VARIANCE = 32'd256;

  // Input item kinds.
  localparam logic ACT_COEF  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // Datapath widths: squares of a coefficient, excess variance, divider.
  localparam int SQR_W = 31;
  localparam int S_W   = 31;
  localparam int DVD_W = 48;
  localparam int DS_W  = 33;

  localparam logic [DVD_W-1:0] SAT_NEG_MAG = 48'd32768;
  localparam logic [DVD_W-1:0] SAT_POS_MAG = 48'd32767;
  localparam logic [COEF_W-1:0] SAT_NEG    = 16'h8000;
  localparam logic [COEF_W-1:0] SAT_POS    = 16'h7FFF;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic       valid;
    logic       center;
    logic [2:0] ring;
  } tap_tag_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_WAIT,
    ST_MULA,
    ST_MULB,
    ST_MULC,
    ST_DIVS,
    ST_DIVW,
    ST_FMUL,
    ST_FDEN,
    ST_FDIV,
    ST_PUT
  } seq_state_t;

endpackage
`default_nettype wire

// File: rtl/core/lvwd_in_if.sv
// Input channel: coefficients and drain ticks.
`default_nettype none
interface lvwd_in_if import lvwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [COEF_W-1:0] coefficient;

  modport source (output valid, output action, output coefficient, input ready);
  modport sink (input valid, input action, input coefficient, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lvwd_out_if.sv
// Output channel: denoised coefficients.
`default_nettype none
interface lvwd_out_if import lvwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] denoised;
  logic              last_of_frame;

  modport source (output valid, output denoised, output last_of_frame, input ready);
  modport sink (input valid, input denoised, input last_of_frame, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lvwd_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface lvwd_cfg_if import lvwd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lvwd_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module lvwd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/lvwd_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lvwd_div import lvwd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [DS_W-1:0]  rem;
  logic [DS_W-1:0]  dsr;
  logic [DVD_W-1:0] quo;
  logic [DS_W:0]    shifted;
  logic             fits;

  assign shifted = {rem, quo[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DVD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DS_W'(shifted - {1'b0, dsr});
      end else begin
        rem <= DS_W'(shifted);
      end
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// File: rtl/core/local_variance_wavelet_denoiser.sv
// Top level of the local variance (local Wiener) wavelet coefficient denoiser.
`default_nettype none
// Coefficients of one image arrive in raster order, one transfer each, and are
// kept in a circular line store deep enough for the largest window. The
// result for a position leaves once the coefficient four rows and four
// columns later has arrived (half the largest window in both directions);
// after the last coefficient of the frame, each drain tick releases the next
// pending result, and after the final result all position counters return to
// zero. A configuration write also restarts the frame. For each result the
// block reads the clipped window around the position from the line store, one
// cell per cycle, feeding one shared multiplier that squares each cell, and
// accumulates count, sum and sum of squares for every nested window at once.
// Then, per window, the same multiplier forms n*sumsq, sum*sum and n*n, and a
// shared 48-step restoring divider gives the variance. The smallest excess over
// the noise variance scales the center coefficient through one more
// multiplication and division. An item that produces a result keeps the input
// from being ready until the result has moved into the output register; the
// window is 3x3 alone in single-window mode, and multi-window mode uses the
// windows 3 through 9. Each window takes three multiplies, the divider start
// and the division; the window scan waits for the read pipeline to empty, and
// the final scaling skips the division when the denominator is zero. The
// divider and the single line store read port set the pace. Items that produce
// no result are taken without leaving the idle state. The block accepts no
// input while it computes, but a finished result waits in an output register
// without holding up the next item.
module local_variance_wavelet_denoiser import lvwd_pkg::*; #(
  parameter int MAX_WIDTH      = 2048,
  parameter int MAX_HEIGHT     = 4096,
  parameter int LARGEST_WINDOW = 9
) (
  input  logic        clk,
  input  logic        rst,
  lvwd_in_if.sink     samples,
  lvwd_out_if.source  results,
  lvwd_cfg_if.sink    cfg
);

  localparam int HALF  = LARGEST_WINDOW / 2;
  localparam int NWIN  = (LARGEST_WINDOW - 1) / 2;
  localparam int CELLS = (2 * NWIN + 1) * (2 * NWIN + 1);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int SUM_W = COEF_W + CNT_W;
  localparam int SQ_W  = SQR_W + CNT_W;
  localparam int MB_W  = SUM_W - 1;
  localparam int MUL_W = SQ_W + MB_W;
  localparam int STORE = (LARGEST_WINDOW - 1) * MAX_WIDTH + LARGEST_WINDOW;
  localparam int AW    = $clog2(STORE);
  localparam int DEPTH = 1 << AW;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int LAG_W = $clog2(HALF * MAX_WIDTH + HALF + 2);
  localparam int JW    = (NWIN > 1) ? $clog2(NWIN) : 1;
  localparam int RW_W  = WW + 3;

  // Configuration registers.
  logic [WREG_W-1:0]  image_width;
  logic [HREG_W-1:0]  image_height;
  logic [NOISE_W-1:0] noise_variance;
  logic               multi_window;

  // Frame geometry after clamping, and the result latency in positions.
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;
  logic [LAG_W-1:0] lag;

  // Position counters on the input and output sides.
  logic [HW-1:0]    in_row;
  logic [WW-1:0]    in_col;
  logic [AW-1:0]    in_addr;
  logic [HW-1:0]    out_row;
  logic [WW-1:0]    out_col;
  logic [AW-1:0]    out_addr;
  logic [LAG_W-1:0] pend;

  seq_state_t state;
  seq_state_t state_next;

  // Window scan.
  logic [2:0]        rad_u;
  logic signed [3:0] rad;
  logic signed [3:0] dr;
  logic signed [3:0] dc;
  logic [AW-1:0]     scan_addr;
  logic [RW_W-1:0]   rw;
  tap_tag_t          tag0;
  tap_tag_t          tag1;
  tap_tag_t          tag2;
  logic [COEF_W-1:0] rdata;
  logic [COEF_W-1:0] v2;
  logic [COEF_W-1:0] x_c;
  logic signed [HW+1:0] row_s;
  logic signed [WW+1:0] col_s;
  logic [3:0]        adr;
  logic [3:0]        adc;

  // Window statistics.
  logic signed [SUM_W-1:0] sum_acc [NWIN];
  logic [SQ_W-1:0]         sq_acc [NWIN];
  logic [CNT_W-1:0]        n_acc [NWIN];
  logic [JW-1:0]           win;
  logic [JW-1:0]           win_last;

  // Shared arithmetic.
  logic [SQ_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MUL_W-1:0]  mul_r;
  logic [DVD_W-1:0]  t1;
  logic [DVD_W-1:0]  num;
  logic [S_W-1:0]    s_min;
  logic [S_W-1:0]    excess;
  logic [DS_W-1:0]   den;
  logic [COEF_W:0]   abs_rd;
  logic [COEF_W:0]   abs_x;
  logic [MB_W-1:0]   abs_sum;
  logic [COEF_W-1:0] y_sat;
  logic [COEF_W-1:0] y_r;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Output register.
  logic              out_v;
  logic [COEF_W-1:0] out_den;
  logic              out_last;

  logic in_xfer;
  logic cfg_xfer;
  logic is_coef;
  logic full;
  logic start_emit;
  logic out_ok;
  logic frame_last;
  logic ram_we;

  // Clamp the written dimensions to the supported range.
  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(image_height);
    end
  end

  assign lag = LAG_W'(HALF) * LAG_W'(eff_w) + LAG_W'(HALF);

  assign cfg.ready  = 1'b1;
  assign cfg_xfer   = cfg.valid && cfg.ready;
  assign in_xfer    = samples.valid && samples.ready;
  assign is_coef    = samples.action == ACT_COEF;
  assign full       = in_row >= eff_h;
  assign out_ok     = !out_v || results.ready;
  assign frame_last = (out_row == HW'(eff_h - 1'b1)) && (out_col == WW'(eff_w - 1'b1));
  assign ram_we     = in_xfer && is_coef && !full;

  // A coefficient releases a result once enough of the frame is in; a drain
  // tick releases one only after the whole frame has arrived.
  assign start_emit = in_xfer &&
                      ((is_coef && !full && (LAG_W'(pend + 1'b1) > lag)) ||
                       (!is_coef && full));

  assign rad_u    = multi_window ? 3'(NWIN) : 3'd1;
  assign rad      = $signed({1'b0, rad_u});
  assign win_last = multi_window ? JW'(NWIN - 1) : '0;
  assign rw       = multi_window ? RW_W'(eff_w) * RW_W'(NWIN) : RW_W'(eff_w);

  // Which nested windows the current cell belongs to, and whether it lies
  // inside the frame at all.
  assign row_s = $signed({2'b00, out_row}) + (HW+2)'(dr);
  assign col_s = $signed({2'b00, out_col}) + (WW+2)'(dc);
  assign adr   = dr[3] ? 4'(-dr) : 4'(dr);
  assign adc   = dc[3] ? 4'(-dc) : 4'(dc);

  always_comb begin
    tag0.valid  = !row_s[HW+1] && (row_s < $signed({2'b00, eff_h})) &&
                  !col_s[WW+1] && (col_s < $signed({2'b00, eff_w}));
    tag0.center = (dr == 4'sd0) && (dc == 4'sd0);
    tag0.ring   = (adr > adc) ? adr[2:0] : adc[2:0];
  end

  lvwd_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_addr),
    .wdata (samples.coefficient),
    .raddr (scan_addr),
    .rdata (rdata)
  );

  lvwd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign abs_rd  = rdata[COEF_W-1] ? (COEF_W+1)'(-{rdata[COEF_W-1], rdata})
                                   : {1'b0, rdata};
  assign abs_x   = x_c[COEF_W-1] ? (COEF_W+1)'(-{x_c[COEF_W-1], x_c}) : {1'b0, x_c};
  assign abs_sum = sum_acc[win][SUM_W-1] ? MB_W'(-sum_acc[win]) : MB_W'(sum_acc[win]);
  assign den     = DS_W'(s_min) + DS_W'(noise_variance);

  // Excess of this window's variance over the noise, floored at zero.
  always_comb begin
    if (div_rsp.quotient > DVD_W'(noise_variance)) begin
      excess = S_W'(div_rsp.quotient - DVD_W'(noise_variance));
    end else begin
      excess = '0;
    end
  end

  // Truncated magnitude back to a signed coefficient, saturated.
  always_comb begin
    if (x_c[COEF_W-1]) begin
      if (div_rsp.quotient > SAT_NEG_MAG) begin
        y_sat = SAT_NEG;
      end else begin
        y_sat = COEF_W'(DVD_W'(0) - div_rsp.quotient);
      end
    end else begin
      if (div_rsp.quotient > SAT_POS_MAG) begin
        y_sat = SAT_POS;
      end else begin
        y_sat = COEF_W'(div_rsp.quotient);
      end
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_emit) state_next = ST_SETUP;
      end
      ST_SETUP: state_next = ST_SCAN;
      ST_SCAN: begin
        if (dr == rad && dc == rad) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (!tag1.valid && !tag2.valid) state_next = ST_MULA;
      end
      ST_MULA: state_next = ST_MULB;
      ST_MULB: state_next = ST_MULC;
      ST_MULC: state_next = ST_DIVS;
      ST_DIVS: state_next = ST_DIVW;
      ST_DIVW: begin
        if (div_rsp.done) state_next = (win == win_last) ? ST_FMUL : ST_MULA;
      end
      ST_FMUL: state_next = ST_FDEN;
      ST_FDEN: state_next = (den == '0) ? ST_PUT : ST_FDIV;
      ST_FDIV: begin
        if (div_rsp.done) state_next = ST_PUT;
      end
      ST_PUT: begin
        if (out_ok) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs steering the shared multiplier and divider.
  always_comb begin
    samples.ready    = (state == ST_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'(mul_r);
    div_req.divisor  = den;
    mul_a            = SQ_W'(abs_rd);
    mul_b            = MB_W'(abs_rd);
    case (state)
      ST_MULA: begin
        mul_a = sq_acc[win];
        mul_b = MB_W'(n_acc[win]);
      end
      ST_MULB: begin
        mul_a = SQ_W'(abs_sum);
        mul_b = abs_sum;
      end
      ST_MULC: begin
        mul_a = SQ_W'(n_acc[win]);
        mul_b = MB_W'(n_acc[win]);
      end
      ST_DIVS: begin
        div_req.start    = 1'b1;
        div_req.dividend = num;
        div_req.divisor  = DS_W'(mul_r);
      end
      ST_FMUL: begin
        mul_a = SQ_W'(s_min);
        mul_b = MB_W'(abs_x);
      end
      ST_FDEN: begin
        div_req.start = (den != '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      noise_variance <= RST_NOISE_VARIANCE;
      multi_window   <= 1'b0;
      in_row         <= '0;
      in_col         <= '0;
      in_addr        <= '0;
      out_row        <= '0;
      out_col        <= '0;
      out_addr       <= '0;
      pend           <= '0;
    end else if (cfg_xfer) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:    image_width    <= cfg.data[WREG_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg.data[HREG_W-1:0];
        REG_NOISE_VARIANCE: noise_variance <= cfg.data[NOISE_W-1:0];
        REG_MULTI_WINDOW:   multi_window   <= cfg.data[0];
        default: begin
        end
      endcase
      in_row   <= '0;
      in_col   <= '0;
      in_addr  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_addr <= '0;
      pend     <= '0;
    end else begin
      if (ram_we) begin
        in_addr <= in_addr + 1'b1;
        pend    <= pend + 1'b1;
        if (in_col == WW'(eff_w - 1'b1)) begin
          in_col <= '0;
          in_row <= in_row + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (state == ST_PUT && out_ok) begin
        if (frame_last) begin
          in_row   <= '0;
          in_col   <= '0;
          in_addr  <= '0;
          out_row  <= '0;
          out_col  <= '0;
          out_addr <= '0;
          pend     <= '0;
        end else begin
          out_addr <= out_addr + 1'b1;
          pend     <= pend - 1'b1;
          if (out_col == WW'(eff_w - 1'b1)) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // Window scan: walk the square around the output position row by row.
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      dr        <= -rad;
      dc        <= -rad;
      scan_addr <= out_addr - AW'(rw) - AW'(rad_u);
    end else if (state == ST_SCAN) begin
      if (dc == rad) begin
        dc        <= -rad;
        dr        <= dr + 1'b1;
        scan_addr <= scan_addr + AW'(eff_w) - AW'({rad_u, 1'b0});
      end else begin
        dc        <= dc + 1'b1;
        scan_addr <= scan_addr + 1'b1;
      end
    end
  end

  // Read pipeline: address, store data, square.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag1 <= (state == ST_SCAN) ? tag0 : '0;
      tag2 <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    v2    <= rdata;
    mul_r <= MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  // Every cell inside the frame adds to all nested windows whose radius reaches it.
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      for (int j = 0; j < NWIN; j++) begin
        sum_acc[j] <= '0;
        sq_acc[j]  <= '0;
        n_acc[j]   <= '0;
      end
    end else if (tag2.valid) begin
      for (int j = 0; j < NWIN; j++) begin
        if (int'(tag2.ring) <= j + 1) begin
          sum_acc[j] <= sum_acc[j] + SUM_W'($signed(v2));
          sq_acc[j]  <= sq_acc[j] + SQ_W'(mul_r[SQR_W-1:0]);
          n_acc[j]   <= n_acc[j] + 1'b1;
        end
      end
      if (tag2.center) begin
        x_c <= v2;
      end
    end
  end

  // Per-window variance and the final scaling.
  always_ff @(posedge clk) begin
    case (state)
      ST_SETUP: begin
        win <= '0;
      end
      ST_MULB: begin
        t1 <= DVD_W'(mul_r);
      end
      ST_MULC: begin
        num <= t1 - DVD_W'(mul_r);
      end
      ST_DIVW: begin
        if (div_rsp.done) begin
          if (win == '0 || excess < s_min) begin
            s_min <= excess;
          end
          win <= win + 1'b1;
        end
      end
      ST_FDEN: begin
        y_r <= '0;
      end
      ST_FDIV: begin
        if (div_rsp.done) begin
          y_r <= y_sat;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (state == ST_PUT && out_ok) begin
      out_v <= 1'b1;
    end else if (results.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUT && out_ok) begin
      out_den  <= y_r;
      out_last <= frame_last;
    end
  end

  assign results.valid         = out_v;
  assign results.denoised      = out_den;
  assign results.last_of_frame = out_last;

  // The divider is only started when it has finished its previous job.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // The backlog between input and output never runs more than one past the latency.
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= LAG_W'(lag + 1'b1))
    else $error("pending result count exceeds latency");

  // The input row counter stops at the frame height.
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    in_row <= eff_h)
    else $error("input row beyond frame");

  // A result leaving the sequencer shows up on the output channel.
  a_put_shows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUT && out_ok) |=> results.valid)
    else $error("result lost at output register");

endmodule
`default_nettype wire

// File: bench/lvwd_checker.sv
// Checker of the denoiser: watches every channel, predicts results and compares them.
module lvwd_checker import lvwd_pkg::*; #(
  parameter int MAX_WIDTH      = 2048,
  parameter int MAX_HEIGHT     = 4096,
  parameter int LARGEST_WINDOW = 9
) (
  input  logic clk,
  input  logic rst,
  lvwd_in_if   samples,
  lvwd_out_if  results,
  lvwd_cfg_if  cfg,
  output int   failures,
  output int   outstanding
);

  localparam int HALF  = LARGEST_WINDOW / 2;
  localparam int DEPTH = (LARGEST_WINDOW - 1) * MAX_WIDTH + LARGEST_WINDOW;

  typedef struct packed {
    logic [COEF_W-1:0] denoised;
    logic              last_of_frame;
  } pixel_t;

  logic signed [COEF_W-1:0] coef_store [DEPTH];
  pixel_t                   expected_pixels [$];

  logic [WREG_W-1:0]  width_reg;
  logic [HREG_W-1:0]  height_reg;
  logic [NOISE_W-1:0] noise_reg;
  logic               multi_reg;
  longint             row_in, col_in, next_out;

  function automatic longint eff_width();
    return (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
  endfunction

  function automatic longint eff_height();
    return (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
  endfunction

  // Window variance less noise, floored at zero, for a k x k window clipped to the image.
  function automatic longint window_excess(longint r, longint c, longint k,
                                           longint w, longint h);
    longint hk, r0, c0, r1, c1, sum, sumsq, n, v, var_q;
    hk = k / 2;
    r0 = (r >= hk) ? r - hk : 0;
    c0 = (c >= hk) ? c - hk : 0;
    r1 = (r + hk <= h - 1) ? r + hk : h - 1;
    c1 = (c + hk <= w - 1) ? c + hk : w - 1;
    sum = 0;
    sumsq = 0;
    for (longint rr = r0; rr <= r1; rr++) begin
      for (longint cc = c0; cc <= c1; cc++) begin
        v = coef_store[(rr * w + cc) % DEPTH];
        sum += v;
        sumsq += v * v;
      end
    end
    n = (r1 - r0 + 1) * (c1 - c0 + 1);
    var_q = (n * sumsq - sum * sum) / (n * n);
    return (var_q > longint'(noise_reg)) ? var_q - longint'(noise_reg) : 0;
  endfunction

  // Produces the next pending pixel and advances the output position.
  function automatic void predict_pixel(longint w, longint h);
    longint q, s, t, x, den, mag, y;
    pixel_t px;
    q = next_out;
    s = window_excess(q / w, q % w, 3, w, h);
    if (multi_reg) begin
      for (longint k = 5; k <= LARGEST_WINDOW; k += 2) begin
        t = window_excess(q / w, q % w, k, w, h);
        if (t < s) s = t;
      end
    end
    x = coef_store[q % DEPTH];
    den = s + longint'(noise_reg);
    if (den == 0) begin
      y = 0;
    end else begin
      mag = ((x < 0 ? -x : x) * s) / den;
      if (x < 0) y = (mag > 32768) ? -32768 : -mag;
      else y = (mag > 32767) ? 32767 : mag;
    end
    px.denoised = y[COEF_W-1:0];
    px.last_of_frame = (q + 1 == w * h);
    expected_pixels.push_back(px);
    next_out = q + 1;
    if (next_out >= w * h) begin
      row_in = 0;
      col_in = 0;
      next_out = 0;
    end
  endfunction

  always @(posedge clk) begin
    longint w, h, pos;
    pixel_t want;
    if (rst) begin
      width_reg = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      noise_reg = RST_NOISE_VARIANCE;
      multi_reg = 1'b0;
      row_in = 0;
      col_in = 0;
      next_out = 0;
      expected_pixels.delete();
      failures = 0;
    end else begin
      // A register write restarts the frame.
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_IMAGE_WIDTH:    width_reg = cfg.data[WREG_W-1:0];
          REG_IMAGE_HEIGHT:   height_reg = cfg.data[HREG_W-1:0];
          REG_NOISE_VARIANCE: noise_reg = cfg.data[NOISE_W-1:0];
          REG_MULTI_WINDOW:   multi_reg = cfg.data[0];
          default: ;
        endcase
        row_in = 0;
        col_in = 0;
        next_out = 0;
      end
      if (samples.valid && samples.ready) begin
        w = eff_width();
        h = eff_height();
        if (samples.action == ACT_COEF) begin
          if (row_in < h) begin
            pos = row_in * w + col_in;
            coef_store[pos % DEPTH] = samples.coefficient;
            col_in++;
            if (col_in >= w) begin
              col_in = 0;
              row_in++;
            end
            if (next_out < w * h && pos + 1 > next_out + HALF * w + HALF)
              predict_pixel(w, h);
          end
        end else if (row_in >= h && next_out < w * h) begin
          predict_pixel(w, h);
        end
      end
      if (results.valid && results.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result denoised=%0d last_of_frame=%0b",
                 $signed(results.denoised), results.last_of_frame);
          failures++;
        end else begin
          want = expected_pixels.pop_front();
          if (results.denoised !== want.denoised) begin
            $error("denoised: expected %0d, actual %0d",
                   $signed(want.denoised), $signed(results.denoised));
            failures++;
          end
          if (results.last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0b, actual %0b",
                   want.last_of_frame, results.last_of_frame);
            failures++;
          end
        end
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

// File: bench/tb_local_variance_wavelet_denoiser.sv
// Stimulus and verdict for the local variance wavelet denoiser testbench.
module tb_local_variance_wavelet_denoiser;
  import lvwd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures;
  int   outstanding;
  int   idle_pct = 32;
  int   items_sent = 0;

  lvwd_in_if  samples ();
  lvwd_out_if results ();
  lvwd_cfg_if cfg ();

  // The clock runs with a period of 12 time units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  local_variance_wavelet_denoiser uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  lvwd_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .results     (results),
    .cfg         (cfg),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // The result side stalls about as often as the sender idles, and never
  // during the calm stretch where idle_pct is zero.
  always @(negedge clk) begin
    results.ready <= ($urandom_range(99) >= idle_pct);
  end

  // One transfer on the sample channel, preceded by a random number of idle
  // cycles. Valid stays high into the next call so that back-to-back items
  // never lower and raise it within the same time step.
  task automatic put_item(input logic act, input logic [COEF_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      samples.valid <= 1'b0;
      @(negedge clk);
    end
    samples.valid <= 1'b1;
    samples.action <= act;
    samples.coefficient <= val;
    do @(posedge clk); while (!samples.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Stops the sender and waits until every predicted result has come out.
  // Items that yield nothing may still be in flight, so a further margin
  // as long as the slowest multi-window result follows.
  task automatic wait_drained();
    samples.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // One register write. Upper bits beyond the register width are random so
  // that the block must mask them.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input logic [CFG_DATA_W-1:0] keep_mask);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= (val & keep_mask) | ($urandom() & ~keep_mask);
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input int w, input int h);
    write_reg(REG_IMAGE_WIDTH, w, 32'h0000_0FFF);
    write_reg(REG_IMAGE_HEIGHT, h, 32'h0000_1FFF);
  endtask

  // Coefficient generator. Style 0 is full range, 1 clusters near a base so
  // that variances are small, 2 is a flat region whose variance is zero, and
  // 3 mixes the two extremes with zero and full-range values.
  function automatic logic [COEF_W-1:0] pick_coef(input int style, input logic [COEF_W-1:0] base);
    case (style)
      0: return COEF_W'($urandom());
      1: return base + COEF_W'($urandom_range(32)) - COEF_W'(16);
      2: return base;
      default: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return COEF_W'($urandom());
        endcase
      end
    endcase
  endfunction

  // Sends one frame of w x h coefficients, or only its first part when cut
  // is set, with noise items sprinkled in: drain ticks before the frame is
  // complete and coefficients after it are both ignored by the block.
  task automatic run_frame(input int w, input int h, input bit cut);
    int total, lag, pending, style, n_send;
    logic [COEF_W-1:0] base;
    total = w * h;
    lag = 4 * w + 4;
    style = $urandom_range(3);
    base = COEF_W'($urandom());
    n_send = cut ? $urandom_range(total > 1 ? total - 1 : 1) : total;
    for (int i = 0; i < n_send; i++) begin
      if ($urandom_range(99) < 5) put_item(ACT_DRAIN, COEF_W'($urandom()));
      put_item(ACT_COEF, pick_coef(style, base));
    end
    if (cut) return;
    if ($urandom_range(99) < 30) put_item(ACT_COEF, COEF_W'($urandom()));
    // Results still held back by the lag leave one per drain tick.
    pending = (total < lag) ? total : lag;
    repeat (pending) put_item(ACT_DRAIN, COEF_W'($urandom()));
    if ($urandom_range(99) < 20) put_item(ACT_DRAIN, COEF_W'($urandom()));
  endtask

  initial begin
    int w, h, phase;
    logic [NOISE_W-1:0] noise;
    samples.valid = 1'b0;
    samples.action = ACT_COEF;
    samples.coefficient = '0;
    results.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_IMAGE_WIDTH;
    cfg.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: a 3x3 frame in multi-window mode with zero noise, fed with
    // both coefficient extremes; an early drain tick, a coefficient after
    // the frame is complete and a drain with nothing pending are all ignored.
    set_geometry(3, 3);
    write_reg(REG_NOISE_VARIANCE, 32'd0, 32'hFFFF_FFFF);
    write_reg(REG_MULTI_WINDOW, 32'd1, 32'h0000_0001);
    put_item(ACT_DRAIN, 16'hFFFF);
    put_item(ACT_COEF, 16'h7FFF);
    put_item(ACT_COEF, 16'h8000);
    put_item(ACT_COEF, 16'h0000);
    put_item(ACT_COEF, 16'h8000);
    put_item(ACT_COEF, 16'h7FFF);
    put_item(ACT_COEF, 16'hFFFF);
    put_item(ACT_COEF, 16'h0001);
    put_item(ACT_COEF, 16'h8000);
    put_item(ACT_COEF, 16'h7FFF);
    put_item(ACT_COEF, 16'h1234);
    repeat (10) put_item(ACT_DRAIN, 16'h0000);
    wait_drained();

    // A flat frame with zero noise has a zero denominator everywhere.
    write_reg(REG_MULTI_WINDOW, 32'd0, 32'h0000_0001);
    set_geometry(2, 2);
    repeat (4) put_item(ACT_COEF, 16'h0040);
    repeat (4) put_item(ACT_DRAIN, 16'h0000);
    wait_drained();

    // Geometry extremes: a zero width clamps to one column and an oversized
    // height clamps to the maximum; an oversized width gives a frame whose
    // lag is never reached. Both are left unfinished.
    set_geometry(0, 8191);
    write_reg(REG_NOISE_VARIANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (20) put_item(ACT_COEF, COEF_W'($urandom()));
    wait_drained();
    set_geometry(4095, 1);
    write_reg(REG_NOISE_VARIANCE, 32'd1, 32'hFFFF_FFFF);
    repeat (10) put_item(ACT_COEF, COEF_W'($urandom()));
    wait_drained();

    // Random phases: each writes the geometry and, at random, the other
    // registers, then sends one to three frames. A stretch of phases runs
    // with no idling on either side.
    phase = 0;
    while (items_sent < 1500) begin
      idle_pct = (phase >= 8 && phase < 13) ? 0 : 32;
      wait_drained();
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
      h = $urandom_range(10, 1);
      set_geometry(w, h);
      if ($urandom_range(1)) begin
        case ($urandom_range(4))
          0: noise = 32'd0;
          1: noise = 32'hFFFF_FFFF;
          2: noise = $urandom_range(4096);
          3: noise = $urandom() >> $urandom_range(31);
          default: noise = $urandom();
        endcase
        write_reg(REG_NOISE_VARIANCE, noise, 32'hFFFF_FFFF);
      end
      if ($urandom_range(2) == 0)
        write_reg(REG_MULTI_WINDOW, $urandom_range(1), 32'h0000_0001);
      repeat ($urandom_range(3, 1)) run_frame(w, h, $urandom_range(99) < 12);
      phase++;
    end

    wait_drained();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
